>>> design/gdsc_pkg.sv
// ---------------------------------------------------------------------------
// gdsc_pkg
// types, constants and calendar tables shared by the date span counter
// ---------------------------------------------------------------------------
`default_nettype none

package gdsc_pkg;

  localparam int unsigned YearW         = 14;
  localparam int unsigned MonthW        = 4;
  localparam int unsigned DayW          = 5;
  localparam int unsigned CountW        = 22;
  localparam int unsigned OrdW          = 23;
  localparam int unsigned LimitW        = 15;
  localparam int unsigned YearLimitDef  = 9999;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned Century       = 100;
  localparam int unsigned LatDate       = 3;

  // floor(y / 100) as (y * Recip100) >> Recip100Shift, exact for 14-bit y
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned RecipW        = 13;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned ProdW         = YearW + RecipW;
  localparam int unsigned QuotW         = ProdW - Recip100Shift;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              include_end;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              bad_date;
  } result_t;

  // per-date result handed from the ordinal pipe to the span stage
  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [OrdW-1:0] ord;
  } date_ord_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, common year
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/gdsc_date_ord.sv
// ---------------------------------------------------------------------------
// gdsc_date_ord
// three-stage pipe: checks one date and forms its day ordinal from 1 jan 0
// ---------------------------------------------------------------------------
`default_nettype none

module gdsc_date_ord #(
  parameter int unsigned YEAR_LIMIT = gdsc_pkg::YearLimitDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [gdsc_pkg::YearW-1:0]     year_i,
  input  wire logic [gdsc_pkg::MonthW-1:0]    month_i,
  input  wire logic [gdsc_pkg::DayW-1:0]      day_i,
  output gdsc_pkg::date_ord_t                 res_o
);
  import gdsc_pkg::*;

  // stage 1: quotient by 100, range flags
  logic                  v1_q;
  logic [YearW-1:0]      y1_q;
  logic [MonthW-1:0]     m1_q;
  logic [DayW-1:0]       d1_q;
  logic [QuotW-1:0]      q1_q;
  logic                  bad1_q;
  logic [ProdW-1:0]      prod1;
  logic                  bad1_d;

  assign prod1  = ProdW'(year_i) * ProdW'(Recip100);
  assign bad1_d = ({1'b0, year_i} > LimitW'(YEAR_LIMIT)) ||
                  (month_i < MonthW'(1)) || (month_i > MonthW'(MonthsPerYear));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    y1_q   <= year_i;
    m1_q   <= month_i;
    d1_q   <= day_i;
    q1_q   <= prod1[ProdW-1:Recip100Shift];
    bad1_q <= bad1_d;
  end

  // stage 2: remainder by 100, leap rule, 365 * year
  logic                  v2_q;
  logic [YearW-1:0]      y2_q;
  logic [MonthW-1:0]     m2_q;
  logic [DayW-1:0]       d2_q;
  logic [QuotW-1:0]      q2_q;
  logic                  rnz2_q;
  logic                  leap2_q;
  logic                  bad2_q;
  logic [OrdW-1:0]       y365_2_q;
  logic [YearW-1:0]      r100;
  logic                  rnz2_d;

  assign r100   = y1_q - (YearW'(q1_q) * YearW'(Century));
  assign rnz2_d = (r100 != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y2_q     <= y1_q;
    m2_q     <= m1_q;
    d2_q     <= d1_q;
    q2_q     <= q1_q;
    rnz2_q   <= rnz2_d;
    leap2_q  <= rnz2_d ? (y1_q[1:0] == 2'b00) : (q1_q[1:0] == 2'b00);
    bad2_q   <= bad1_q;
    y365_2_q <= OrdW'(y1_q) * OrdW'(DaysPerYear);
  end

  // stage 3: leap-day corrections, month offset, day check
  logic [OrdW-1:0]       c4;
  logic [OrdW-1:0]       c100;
  logic [OrdW-1:0]       c400;
  logic [OrdW-1:0]       cum;
  logic                  day_ok;
  logic [OrdW-1:0]       ord_d;
  logic                  v3_q;
  logic                  ok3_q;
  logic [OrdW-1:0]       ord3_q;

  assign c4     = OrdW'(({1'b0, y2_q} + (YearW+1)'(3)) >> 2);
  assign c100   = OrdW'(q2_q) + OrdW'(rnz2_q);
  assign c400   = OrdW'(q2_q >> 2) + OrdW'(rnz2_q || (q2_q[1:0] != 2'b00));
  assign cum    = OrdW'(days_before(m2_q)) +
                  OrdW'(leap2_q && (m2_q > MonthW'(2)));
  assign day_ok = (d2_q != '0) && (d2_q <= month_len(m2_q, leap2_q));
  assign ord_d  = y365_2_q + c4 - c100 + c400 + cum + OrdW'(d2_q) - OrdW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok3_q  <= !bad2_q && day_ok;
    ord3_q <= ord_d;
  end

  assign res_o = '{valid: v3_q, ok: ok3_q, ord: ord3_q};

endmodule

`default_nettype wire

>>> design/gregorian_date_span_counter.sv
// ---------------------------------------------------------------------------
// gregorian_date_span_counter
// days between two proleptic gregorian dates, with date checking
// ---------------------------------------------------------------------------
// Takes one beat per clock: busy never rises, so start may be held high to
// stream a new pair of dates every cycle. Each beat gives exactly one result
// on done_o / result_o once it has passed the three stages of the per-date
// ordinal pipe and then the span register; results cannot be held off by
// the receiver and each stays on the ports for a single cycle. The ordinal
// pipe works in this order: a reciprocal multiply for year / 100,
// then remainder, leap rule and 365 * year, then the ordinal sum. A month
// outside 1 to 12, a day outside the month, or a year above YEAR_LIMIT in
// either date sets bad_date and forces day_count to zero. Counts above the
// 22-bit range saturate, which needs a raised YEAR_LIMIT.
// ---------------------------------------------------------------------------
`default_nettype none

module gregorian_date_span_counter #(
  parameter int unsigned YEAR_LIMIT = gdsc_pkg::YearLimitDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire gdsc_pkg::item_t  item_i,
  output logic                  done_o,
  output gdsc_pkg::result_t     result_o
);
  import gdsc_pkg::*;

  // fully pipelined, never refuses a beat
  assign busy = 1'b0;

  logic      take;
  date_ord_t start_ord;
  date_ord_t end_ord;

  assign take = start && !busy;

  // one ordinal pipe per date, running in lockstep
  gdsc_date_ord #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_start_ord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .year_i  (item_i.start_year),
    .month_i (item_i.start_month),
    .day_i   (item_i.start_day),
    .res_o   (start_ord)
  );

  gdsc_date_ord #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_end_ord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .year_i  (item_i.end_year),
    .month_i (item_i.end_month),
    .day_i   (item_i.end_day),
    .res_o   (end_ord)
  );

  // include_end rides alongside the ordinal pipes
  logic [LatDate-1:0] inc_q;

  always_ff @(posedge clk_i) begin
    inc_q <= {inc_q[LatDate-2:0], item_i.include_end};
  end

  // span stage: flag bad dates; else clamp spans below zero, add end day, saturate
  logic [OrdW:0]   span;
  logic [OrdW:0]   count;
  logic            both_ok;
  logic            done_q;
  result_t         result_q;
  result_t         result_d;

  assign span    = (start_ord.ord < end_ord.ord) ?
                   ({1'b0, end_ord.ord} - {1'b0, start_ord.ord}) : '0;
  assign count   = span + (OrdW+1)'(inc_q[LatDate-1]);
  assign both_ok = start_ord.ok && end_ord.ok;

  always_comb begin
    result_d = '0;
    if (!both_ok) begin
      result_d.bad_date = 1'b1;
    end else if (count > (OrdW+1)'(CountMax)) begin
      result_d.day_count = CountMax;
    end else begin
      result_d.day_count = count[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_ord.valid && end_ord.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // both ordinal pipes must stay aligned beat for beat
  a_pipes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ord.valid == end_ord.valid)
    else $error("ordinal pipes out of step");

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##(LatDate+1) done_o)
    else $error("result missing after accepted beat");

  // no result without a matching beat taken earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, LatDate+1))
    else $error("result without accepted beat");

  // a bad date always reports a zero count
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.bad_date) |-> (result_o.day_count == '0))
    else $error("nonzero count on bad date");

endmodule

`default_nettype wire

>>> bench/gregorian_date_span_counter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_date_span_counter_tb
// self-checking bench for the gregorian date span counter
// ---------------------------------------------------------------------------
// Drives date pairs through the start / busy command port and predicts each
// day count with a calendar model kept inside the bench: day numbers since
// 1 january of year 0 under the 4 / 100 / 400 leap rule, then the
// difference. Directed beats cover the calendar extremes and every kind of
// bad date. Random traffic follows in three phases: back to back, heavy
// sender gaps and light sender gaps. A pause for all pending counts to
// drain separates the phases.
// ---------------------------------------------------------------------------

module gregorian_date_span_counter_tb;
  import gdsc_pkg::*;

  localparam int unsigned YearMax       = YearLimitDef;
  localparam int unsigned YearTop       = (1 << YearW) - 1;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned IdleNone      = 0;
  localparam int unsigned IdleHeavy     = 45;
  localparam int unsigned IdleLight     = 11;
  localparam int unsigned MaxGap        = 8;

  // one accepted beat and the count it should produce
  typedef struct {
    item_t   beat;
    result_t want;
  } span_check_t;

  logic    clk   = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    done;
  result_t result;

  span_check_t pending_spans[$];
  int unsigned fail_count   = 0;
  int unsigned stall_cycles = 0;

  always #5 clk = ~clk;

  gregorian_date_span_counter dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done),
    .result_o (result)
  );

  // ---- calendar model ----------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2:             len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    if (y > YearMax) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  // days since 1 jan of year 0; only called on valid dates
  function automatic int unsigned day_number(int unsigned y, int unsigned m,
                                             int unsigned d);
    int unsigned n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned mm = 1; mm < m; mm++) n += month_length(y, mm);
    return n + d - 1;
  endfunction

  function automatic result_t span_days(item_t it);
    result_t         r;
    int unsigned     first_day;
    int unsigned     last_day;
    longint unsigned span;
    r = '0;
    if (!date_valid(it.start_year, it.start_month, it.start_day) ||
        !date_valid(it.end_year, it.end_month, it.end_day)) begin
      r.bad_date = 1'b1;
      return r;
    end
    first_day = day_number(it.start_year, it.start_month, it.start_day);
    last_day  = day_number(it.end_year, it.end_month, it.end_day);
    span = (last_day > first_day) ? longint'(last_day - first_day) : 0;
    span += it.include_end;
    if (span > CountMax) span = CountMax;
    r.day_count = span[CountW-1:0];
    return r;
  endfunction

  // ---- stimulus helpers --------------------------------------------------

  function automatic item_t make_item(int unsigned sy, int unsigned sm, int unsigned sd,
                                      int unsigned ey, int unsigned em, int unsigned ed,
                                      bit inc);
    item_t it;
    it.start_year  = YearW'(sy);
    it.start_month = MonthW'(sm);
    it.start_day   = DayW'(sd);
    it.end_year    = YearW'(ey);
    it.end_month   = MonthW'(em);
    it.end_day     = DayW'(ed);
    it.include_end = inc;
    return it;
  endfunction

  // century and leap boundaries come up often
  function automatic int unsigned pick_year();
    int unsigned y;
    case ($urandom_range(0, 15))
      0:       y = 0;
      1:       y = 100;
      2:       y = 400;
      3:       y = 1900;
      4:       y = 2000;
      5:       y = YearMax;
      6:       y = $urandom_range(0, YearMax / 4) * 4;
      default: y = $urandom_range(0, YearMax);
    endcase
    return y;
  endfunction

  function automatic item_t random_date_pair();
    item_t       it;
    int unsigned sy;
    int          ey;
    sy = pick_year();
    if ($urandom_range(0, 1)) begin
      ey = int'(sy) + $urandom_range(0, 6) - 3;
      if (ey < 0) ey = 0;
      if (ey > int'(YearMax)) ey = YearMax;
    end else begin
      ey = pick_year();
    end
    it.start_year  = YearW'(sy);
    it.start_month = MonthW'($urandom_range(1, 12));
    it.start_day   = DayW'($urandom_range(1, month_length(sy, it.start_month)));
    it.end_year    = YearW'(ey);
    it.end_month   = MonthW'($urandom_range(1, 12));
    it.end_day     = DayW'($urandom_range(1, month_length(ey, it.end_month)));
    it.include_end = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // present one beat and hold it until the block takes it
  task automatic send_item(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_spans.push_back('{beat: it, want: span_days(it)});
  endtask

  // sender gap; the item bus carries junk meanwhile, which must be ignored
  task automatic idle_gap(int unsigned n);
    logic [63:0] junk;
    if (n != 0) begin
      junk  = {$urandom, $urandom};
      start <= 1'b0;
      item  <= junk[$bits(item_t)-1:0];
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  // ---- tests -------------------------------------------------------------

  task automatic test_calendar_extremes();
    send_item(make_item(0, 1, 1, YearMax, 12, 31, 1'b0));    // widest span
    send_item(make_item(0, 1, 1, YearMax, 12, 31, 1'b1));    // largest count
    send_item(make_item(2024, 5, 17, 2024, 5, 17, 1'b0));    // same day
    send_item(make_item(2024, 5, 17, 2024, 5, 17, 1'b1));
    send_item(make_item(YearMax, 12, 31, 0, 1, 1, 1'b1));    // start after end
    send_item(make_item(YearMax, 12, 31, 0, 1, 1, 1'b0));
    send_item(make_item(0, 2, 29, 0, 3, 1, 1'b0));           // year zero is leap
    send_item(make_item(1899, 12, 31, 1900, 3, 1, 1'b0));    // century not leap
    send_item(make_item(1999, 2, 28, 2000, 3, 1, 1'b1));     // 400 year leap
    send_item(make_item(2023, 12, 31, 2024, 1, 1, 1'b0));    // year rollover
    send_item(make_item(1, 1, 31, 1, 2, 1, 1'b0));           // month rollover
    send_item(make_item(2000, 2, 29, 2004, 2, 29, 1'b1));
  endtask

  task automatic test_bad_dates();
    send_item(make_item(2020, 0, 10, 2021, 1, 1, 1'b1));     // month zero
    send_item(make_item(2020, 1, 10, 2021, 13, 1, 1'b0));    // month above 12
    send_item(make_item(2020, 15, 31, 2021, 15, 31, 1'b1));
    send_item(make_item(2020, 6, 0, 2021, 1, 1, 1'b1));      // day zero
    send_item(make_item(2020, 1, 1, 2023, 4, 31, 1'b0));     // past end of month
    send_item(make_item(1900, 2, 29, 1901, 1, 1, 1'b0));     // no leap day
    send_item(make_item(2024, 2, 30, 2025, 1, 1, 1'b1));
    send_item(make_item(YearMax + 1, 1, 1, YearMax, 1, 1, 1'b1)); // year over limit
    send_item(make_item(YearMax, 12, 31, YearMax + 1, 1, 1, 1'b0));
    send_item(make_item(YearTop, 15, 31, YearTop, 15, 31, 1'b1));  // all ones
    send_item(make_item(0, 0, 0, 0, 0, 0, 1'b0));                  // all zeros
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned idle_pct);
    item_t       it;
    logic [63:0] noise;
    int unsigned kind;
    int unsigned len;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      it   = random_date_pair();
      if (kind < 10) begin
        // raw noise on every field
        noise = {$urandom, $urandom};
        it    = noise[$bits(item_t)-1:0];
      end else if (kind < 22) begin
        // a sound pair with one field broken
        case ($urandom_range(0, 5))
          0: it.start_month = ($urandom_range(0, 3) == 0) ? '0 :
                              MonthW'($urandom_range(13, 15));
          1: it.end_month   = ($urandom_range(0, 3) == 0) ? '0 :
                              MonthW'($urandom_range(13, 15));
          2: it.start_day   = '0;
          3: begin
            len = month_length(it.end_year, it.end_month);
            it.end_day = (len == 31) ? '0 : DayW'($urandom_range(len + 1, 31));
          end
          4: it.start_year = YearW'($urandom_range(YearMax + 1, YearTop));
          default: it.end_year = YearW'($urandom_range(YearMax + 1, YearTop));
        endcase
      end else if (kind < 30) begin
        it.end_year  = it.start_year;
        it.end_month = it.start_month;
        it.end_day   = it.start_day;
      end
      send_item(it);
      if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, MaxGap));
    end
  endtask

  // ---- result checking ---------------------------------------------------

  // every done strobe must match the oldest pending beat
  always @(posedge clk) begin
    span_check_t exp;
    if (rst_n && done) begin
      if (pending_spans.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: count %0d bad %0b",
                                  result.day_count, result.bad_date));
      end else begin
        exp = pending_spans.pop_front();
        if (result.day_count !== exp.want.day_count)
          report_mismatch($sformatf(
            "%0d-%0d-%0d to %0d-%0d-%0d inc %0b: day_count %0d, expected %0d",
            exp.beat.start_year, exp.beat.start_month, exp.beat.start_day,
            exp.beat.end_year, exp.beat.end_month, exp.beat.end_day,
            exp.beat.include_end, result.day_count, exp.want.day_count));
        if (result.bad_date !== exp.want.bad_date)
          report_mismatch($sformatf(
            "%0d-%0d-%0d to %0d-%0d-%0d inc %0b: bad_date %0b, expected %0b",
            exp.beat.start_year, exp.beat.start_month, exp.beat.start_day,
            exp.beat.end_year, exp.beat.end_month, exp.beat.end_day,
            exp.beat.include_end, result.bad_date, exp.want.bad_date));
      end
    end
  end

  // watchdog: too long with neither a beat taken nor a result seen
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---- sequence ----------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_calendar_extremes();
    test_bad_dates();
    wait_for_drain();

    test_random_traffic(ItemsPerPhase, IdleNone);
    wait_for_drain();
    test_random_traffic(ItemsPerPhase, IdleHeavy);
    wait_for_drain();
    test_random_traffic(ItemsPerPhase, IdleLight);
    wait_for_drain();

    // catch any stray strobe after the last expected count
    repeat (SettleCycles) @(posedge clk);
    if (pending_spans.size() != 0)
      report_mismatch($sformatf("%0d counts never arrived", pending_spans.size()));

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gdsc_pkg.sv
design/gdsc_date_ord.sv
design/gregorian_date_span_counter.sv
bench/gregorian_date_span_counter_tb.sv
